@@ src/rlcm_pkg.sv @@
// rlcm_pkg: shared types for the running lcm block
// operation codes and request bundle for the shift-add/subtract unit
// no dependencies
`timescale 1ns / 1ps

package rlcm_pkg;

  // operation performed by the shared unit
  typedef enum logic {
    ALU_DIV,
    ALU_MUL
  } alu_mode_t;

  // request from the sequencer to the shared unit
  typedef struct packed {
    logic      go;
    alu_mode_t mode;
  } alu_req_t;

endpackage

@@ src/running_lcm_euclid.sv @@
// running_lcm_euclid: running least common multiple over sets of numbers
// sequencer around the shared bit-serial divide/multiply unit
// depends on rlcm_pkg and rlcm_alu
`timescale 1ns / 1ps

// Usage
//   Input: drive in_value and in_last_item with start high; the item is taken
//   at a clock edge where start is high and busy is low. busy stays high while
//   the item is worked on. in_last_item marks the final number of a set.
//   Output: on the last item of a set, out_valid pulses for one cycle with
//   out_lcm_result and out_overflow; the receiver must take it then.
//   Overflow: a multiple above RESULT_BITS bits gives all ones and flag set;
//   later numbers of that set are skipped.
// Sequence (W = RESULT_BITS)
//   First number of a set, zero operand, oversized or skipped item: goes
//   straight to the finish step without the shared unit.
//   Folding a number in: one W-step division for each Euclid remainder,
//   one more for the quotient and one W-step multiply. The single shared
//   adder in rlcm_alu is used once per bit.
//   The result strobe is high in the first cycle with busy low.
// Reset: synchronous active-low rst_n clears the running multiple and
//   starts a fresh set.
module running_lcm_euclid import rlcm_pkg::*; #(
  parameter int RESULT_BITS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_value,
  input  logic        in_last_item,
  output logic        out_valid,
  output logic [63:0] out_lcm_result,
  output logic        out_overflow
);

  localparam int W = RESULT_BITS;
  localparam logic [W-1:0] MAXV = '1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_GCD,
    S_QUOT,
    S_MUL,
    S_FIN
  } state_t;

  state_t       state_r;
  logic [W-1:0] m_r;
  logic         set_r;
  logic         ovf_r;
  logic [W-1:0] x_r;
  logic         last_r;
  logic [W-1:0] a_r;
  logic [W-1:0] b_r;
  alu_req_t     req_r;
  logic         out_valid_r;
  logic [63:0]  out_lcm_r;
  logic         out_ovf_r;

  logic         alu_done;
  logic [W-1:0] alu_hi;
  logic [W-1:0] alu_lo;
  logic [63:0]  x_ext;
  logic [W-1:0] x_w;
  logic         x_big;

  // input value against the result limit
  assign x_ext = 64'(in_value);
  assign x_w   = x_ext[W-1:0];
  assign x_big = x_ext > 64'(MAXV);

  rlcm_alu #(.W(W)) u_alu (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (req_r),
    .op_a   (a_r),
    .op_b   (b_r),
    .done   (alu_done),
    .res_hi (alu_hi),
    .res_lo (alu_lo)
  );

  // sequencer, running state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      m_r         <= '0;
      set_r       <= 1'b0;
      ovf_r       <= 1'b0;
      req_r       <= '{go: 1'b0, mode: ALU_DIV};
      out_valid_r <= 1'b0;
    end else begin
      req_r.go    <= 1'b0;
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            x_r     <= x_w;
            last_r  <= in_last_item;
            state_r <= S_FIN;
            priority if (ovf_r) begin
            end else if (!set_r) begin
              if (x_big) ovf_r <= 1'b1;
              else       m_r   <= x_w;
            end else if (in_value == 32'd0 || m_r == '0) begin
              m_r <= '0;
            end else if (x_big) begin
              ovf_r <= 1'b1;
            end else begin
              // first remainder of the gcd loop
              a_r     <= m_r;
              b_r     <= x_w;
              req_r   <= '{go: 1'b1, mode: ALU_DIV};
              state_r <= S_GCD;
            end
          end
        end
        S_GCD: begin
          if (alu_done) begin
            if (alu_hi == '0) begin
              // b_r holds the gcd, divide the multiple by it
              a_r     <= m_r;
              state_r <= S_QUOT;
            end else begin
              a_r <= b_r;
              b_r <= alu_hi;
            end
            req_r <= '{go: 1'b1, mode: ALU_DIV};
          end
        end
        S_QUOT: begin
          if (alu_done) begin
            a_r     <= x_r;
            b_r     <= alu_lo;
            req_r   <= '{go: 1'b1, mode: ALU_MUL};
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          if (alu_done) begin
            if (alu_hi != '0) ovf_r <= 1'b1;
            else              m_r   <= alu_lo;
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          // a last item closes the set
          set_r <= !last_r;
          if (last_r) begin
            out_valid_r <= 1'b1;
            out_lcm_r   <= ovf_r ? 64'(MAXV) : 64'(m_r);
            out_ovf_r   <= ovf_r;
            m_r         <= '0;
            ovf_r       <= 1'b0;
          end
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy           = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_lcm_result = out_lcm_r;
  assign out_overflow   = out_ovf_r;

  // result strobe only follows the finish step of a last item
  a_out_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == S_FIN && last_r))
    else $error("result strobe without a finished last item");

  // overflowed results are saturated
  a_ovf_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_overflow) |-> (out_lcm_result == 64'(MAXV)))
    else $error("overflow result not saturated");

  // an accepted item makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  // the shared unit is only started during a fold
  a_go_in_fold: assert property (@(posedge clk) disable iff (!rst_n)
    req_r.go |-> (state_r == S_GCD || state_r == S_QUOT || state_r == S_MUL))
    else $error("shared unit started outside a fold");

endmodule

@@ src/rlcm_alu.sv @@
// rlcm_alu: bit-serial shared unit, restoring divide or shift-add multiply
// one adder/subtractor reused every cycle while busy, W steps per operation
// depends on rlcm_pkg
`timescale 1ns / 1ps

module rlcm_alu import rlcm_pkg::*; #(
  parameter int W = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  alu_req_t     req,
  input  logic [W-1:0] op_a,   // dividend or multiplier
  input  logic [W-1:0] op_b,   // divisor or multiplicand
  output logic         done,
  output logic [W-1:0] res_hi, // remainder or product high half
  output logic [W-1:0] res_lo  // quotient or product low half
);

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  hi_r, hi_nxt;
  logic [W-1:0]  lo_r, lo_nxt;
  logic [W-1:0]  d_r;
  alu_mode_t     mode_r;
  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;

  logic [W+1:0]  add_a, add_b, add_sum;
  logic          sub;
  logic [W:0]    shifted;

  // shared adder, subtract for divide
  always_comb begin
    shifted = {hi_r, lo_r[W-1]};
    sub     = (mode_r == ALU_DIV);
    if (sub) begin
      add_a = {1'b0, shifted};
      add_b = ~{2'b00, d_r};
    end else begin
      add_a = {2'b00, hi_r};
      add_b = lo_r[0] ? {2'b00, d_r} : '0;
    end
    add_sum = add_a + add_b + {{(W+1){1'b0}}, sub};
  end

  // next partial remainder/product
  always_comb begin
    if (mode_r == ALU_DIV) begin
      // top bit set means the trial subtract borrowed
      if (add_sum[W+1]) hi_nxt = shifted[W-1:0];
      else              hi_nxt = add_sum[W-1:0];
      lo_nxt = {lo_r[W-2:0], ~add_sum[W+1]};
    end else begin
      hi_nxt = add_sum[W:1];
      lo_nxt = {add_sum[0], lo_r[W-1:1]};
    end
  end

  // step counter, busy flag and done strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.go) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.go) begin
      hi_r   <= '0;
      lo_r   <= op_a;
      d_r    <= op_b;
      mode_r <= req.mode;
    end else if (busy_r) begin
      hi_r <= hi_nxt;
      lo_r <= lo_nxt;
    end
  end

  assign done   = done_r;
  assign res_hi = hi_r;
  assign res_lo = lo_r;

endmodule

@@ dv/running_lcm_euclid_test.sv @@
// running_lcm_euclid_test: self-checking bench for the running lcm block
// directed sets from a table, then random sets scored by an in-bench lcm predictor
// depends on src/running_lcm_euclid.sv (and rlcm_pkg, rlcm_alu through it)
`timescale 1ns / 1ps

module running_lcm_euclid_test;

  localparam int          RESULT_BITS   = 64;
  localparam logic [63:0] LCM_LIMIT     = {64{1'b1}} >> (64 - RESULT_BITS);
  localparam int          RANDOM_ITEMS  = 2000;
  localparam int          QUIET_TAIL    = 200;
  // longest fold: ~48 remainder steps plus quotient and multiply
  localparam int          DRAIN_CYCLES  = 52 * (RESULT_BITS + 2) + 2;

  // one expected result
  typedef struct packed {
    logic [63:0] lcm;
    logic        ovf;
  } lcm_res_t;

  // one row of the directed table
  typedef struct packed {
    logic [31:0] value;
    logic        last;
    logic        fixed;
    logic [63:0] exp_lcm;
    logic        exp_ovf;
  } dir_row_t;

  logic        clk          = 1'b0;
  logic        rst_n        = 1'b0;
  logic        start        = 1'b0;
  logic [31:0] in_value     = '0;
  logic        in_last_item = 1'b0;
  logic        busy;
  logic        out_valid;
  logic [63:0] out_lcm_result;
  logic        out_overflow;

  // predictor state
  logic [63:0] pred_multiple;
  logic        pred_started;
  logic        pred_overflow;

  lcm_res_t pending_lcm_q[$];
  dir_row_t dir_rows[$];

  int error_count   = 0;
  int items_sent    = 0;
  int sets_done     = 0;
  int overflow_sets = 0;
  int zero_sets     = 0;

  running_lcm_euclid #(
    .RESULT_BITS(RESULT_BITS)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_value      (in_value),
    .in_last_item  (in_last_item),
    .out_valid     (out_valid),
    .out_lcm_result(out_lcm_result),
    .out_overflow  (out_overflow)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    error_count++;
  endtask

  function automatic logic [63:0] euclid_gcd(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] r;
    while (b != 0) begin
      r = a % b;
      a = b;
      b = r;
    end
    return a;
  endfunction

  // fold one item into the predicted running multiple
  task automatic fold_running_lcm(input logic [31:0] v, input logic last,
                                  output bit has_out, output lcm_res_t res);
    logic [63:0] x;
    logic [63:0] g;
    logic [63:0] q;
    x = {32'd0, v};
    has_out = 1'b0;
    res = '0;
    if (!pred_overflow) begin
      if (!pred_started) begin
        if (x > LCM_LIMIT) pred_overflow = 1'b1;
        else pred_multiple = x;
      end else if (x == 0 || pred_multiple == 0) begin
        pred_multiple = '0;
      end else begin
        g = euclid_gcd(pred_multiple, x);
        q = pred_multiple / g;
        if (q > LCM_LIMIT / x) pred_overflow = 1'b1;
        else pred_multiple = q * x;
      end
    end
    pred_started = 1'b1;
    if (last) begin
      has_out = 1'b1;
      res.lcm = pred_overflow ? LCM_LIMIT : pred_multiple;
      res.ovf = pred_overflow;
      pred_multiple = '0;
      pred_started  = 1'b0;
      pred_overflow = 1'b0;
    end
  endtask

  // present one item and hold it until taken
  task automatic drive_item(input logic [31:0] v, input logic last, input logic fixed,
                            input logic [63:0] fix_lcm, input logic fix_ovf);
    bit       has_out;
    lcm_res_t res;
    start        <= 1'b1;
    in_value     <= v;
    in_last_item <= last;
    do @(posedge clk); while (busy !== 1'b0);
    fold_running_lcm(v, last, has_out, res);
    if (has_out) begin
      if (fixed) begin
        res.lcm = fix_lcm;
        res.ovf = fix_ovf;
      end
      pending_lcm_q.push_back(res);
    end
    items_sent++;
  endtask

  task automatic hold_off(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // value mix: mostly small and smooth numbers so sets run deep before overflow
  function automatic logic [31:0] pick_value();
    int unsigned sel;
    sel = $urandom_range(0, 19);
    case (sel)
      0:         return 32'd0;
      1:         return 32'hFFFF_FFFF;
      2, 3, 4:   return $urandom;
      15, 16, 17: return 32'd1 << $urandom_range(0, 31);
      18, 19:    return $urandom_range(32'hFFFF_FFFF, 32'hFFFF_0000);
      default: begin
        if (sel < 10) return $urandom_range(1, 64);
        return $urandom_range(1, 4096);
      end
    endcase
  endfunction

  // result scoring
  always @(posedge clk) begin
    lcm_res_t e;
    if (rst_n && out_valid === 1'b1) begin
      if (pending_lcm_q.size() == 0) begin
        report_mismatch($sformatf("result %h/%b with no item pending",
                                  out_lcm_result, out_overflow));
      end else begin
        e = pending_lcm_q.pop_front();
        if (out_lcm_result !== e.lcm)
          report_mismatch($sformatf("set %0d lcm %h, want %h", sets_done,
                                    out_lcm_result, e.lcm));
        if (out_overflow !== e.ovf)
          report_mismatch($sformatf("set %0d overflow %b, want %b", sets_done,
                                    out_overflow, e.ovf));
      end
      sets_done++;
      if (out_overflow === 1'b1) overflow_sets++;
      if (out_lcm_result === 64'd0) zero_sets++;
    end
  end

  // stimulus
  initial begin
    int  set_len;
    int  idle_odds;
    int  total_items;
    bit  paused_once;
    bit  quiet;
    pred_multiple = '0;
    pred_started  = 1'b0;
    pred_overflow = 1'b0;
    paused_once   = 1'b0;

    // directed sets: extremes, zeros, overflow and skipped items after it
    dir_rows.push_back(dir_row_t'{32'd1,          1'b1, 1'b1, 64'd1, 1'b0});
    dir_rows.push_back(dir_row_t'{32'hFFFF_FFFF,  1'b1, 1'b1, 64'hFFFF_FFFF, 1'b0});
    dir_rows.push_back(dir_row_t'{32'd0,          1'b1, 1'b1, 64'd0, 1'b0});
    dir_rows.push_back(dir_row_t'{32'd12,         1'b0, 1'b0, 64'd0, 1'b0});
    dir_rows.push_back(dir_row_t'{32'd18,         1'b0, 1'b0, 64'd0, 1'b0});
    dir_rows.push_back(dir_row_t'{32'd8,          1'b1, 1'b0, 64'd0, 1'b0});
    dir_rows.push_back(dir_row_t'{32'd0,          1'b0, 1'b0, 64'd0, 1'b0});
    dir_rows.push_back(dir_row_t'{32'd7,          1'b1, 1'b1, 64'd0, 1'b0});
    dir_rows.push_back(dir_row_t'{32'd6,          1'b0, 1'b0, 64'd0, 1'b0});
    dir_rows.push_back(dir_row_t'{32'd0,          1'b0, 1'b0, 64'd0, 1'b0});
    dir_rows.push_back(dir_row_t'{32'd5,          1'b1, 1'b1, 64'd0, 1'b0});
    dir_rows.push_back(dir_row_t'{32'hFFFF_FFFF,  1'b0, 1'b0, 64'd0, 1'b0});
    dir_rows.push_back(dir_row_t'{32'hFFFF_FFFE,  1'b0, 1'b0, 64'd0, 1'b0});
    dir_rows.push_back(dir_row_t'{32'hFFFF_FFFD,  1'b0, 1'b0, 64'd0, 1'b0});
    dir_rows.push_back(dir_row_t'{32'd9,          1'b1, 1'b1, LCM_LIMIT, 1'b1});
    // (2^32-1) * 641 * 6700417 lands exactly on the 64-bit limit
    dir_rows.push_back(dir_row_t'{32'hFFFF_FFFF,  1'b0, 1'b0, 64'd0, 1'b0});
    dir_rows.push_back(dir_row_t'{32'd641,        1'b0, 1'b0, 64'd0, 1'b0});
    dir_rows.push_back(dir_row_t'{32'd6700417,    1'b1, 1'b1, LCM_LIMIT, 1'b0});
    dir_rows.push_back(dir_row_t'{32'h8000_0000,  1'b0, 1'b0, 64'd0, 1'b0});
    dir_rows.push_back(dir_row_t'{32'h4000_0000,  1'b1, 1'b0, 64'd0, 1'b0});
    dir_rows.push_back(dir_row_t'{32'hFFFF_FFFB,  1'b0, 1'b0, 64'd0, 1'b0});
    dir_rows.push_back(dir_row_t'{32'hFFFF_FFEF,  1'b0, 1'b0, 64'd0, 1'b0});
    dir_rows.push_back(dir_row_t'{32'd2,          1'b1, 1'b0, 64'd0, 1'b0});
    dir_rows.push_back(dir_row_t'{32'd1,          1'b0, 1'b0, 64'd0, 1'b0});
    dir_rows.push_back(dir_row_t'{32'd1,          1'b1, 1'b1, 64'd1, 1'b0});

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if ($urandom_range(0, 3) == 0) hold_off($urandom_range(1, 18));
      drive_item(dir_rows[i].value, dir_rows[i].last, dir_rows[i].fixed,
                 dir_rows[i].exp_lcm, dir_rows[i].exp_ovf);
    end

    // let the directed sets drain completely before random traffic
    start <= 1'b0;
    while (pending_lcm_q.size() != 0) @(posedge clk);
    @(posedge clk);

    // random sets, idle pattern rerolled per set, quiet at the tail
    total_items = dir_rows.size() + RANDOM_ITEMS;
    idle_odds = 0;
    while (items_sent < total_items) begin
      quiet = (items_sent >= total_items - QUIET_TAIL);
      if (!paused_once && items_sent >= dir_rows.size() + RANDOM_ITEMS / 2) begin
        start <= 1'b0;
        while (pending_lcm_q.size() != 0) @(posedge clk);
        paused_once = 1'b1;
      end
      idle_odds = quiet ? 0 : $urandom_range(0, 3);
      set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
      for (int k = 0; k < set_len; k++) begin
        if (idle_odds != 0 && $urandom_range(0, 7) < idle_odds)
          hold_off($urandom_range(1, 18));
        drive_item(pick_value(), (k == set_len - 1), 1'b0, 64'd0, 1'b0);
      end
    end
    start <= 1'b0;

    // wait for every result, then a little longer for anything stray
    while (pending_lcm_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_lcm_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_lcm_q.size()));

    $display("covered %0d items in %0d sets: %0d overflowed, %0d gave zero",
             items_sent, sets_done, overflow_sets, zero_sets);
    if (error_count == 0) begin
      $display("running_lcm_euclid regression: pass");
    end else begin
      $display("%0d mismatches", error_count);
      $display("running_lcm_euclid regression: fail");
    end
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin
    #(64'd600_000_000);
    $display("timeout with %0d results pending", pending_lcm_q.size());
    $display("running_lcm_euclid regression: fail");
    $finish;
  end

endmodule
